### sv/pmw_pkg.sv
`default_nettype none

package pmw_pkg;

  localparam int unsigned NodeBits  = 7;
  localparam int unsigned InWBits   = 16;
  localparam int unsigned TotalBits = 22;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_PICK,
    ST_EMIT
  } step_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_CLR_MORE,
    C_WAIT_RUN,
    C_N_MORE,
    C_NOT_FOUND
  } cond_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_WRAP_N,
    CNT_INC
  } cnt_op_e;

  typedef struct packed {
    logic    busy;
    logic    clr_wr;
    logic    key_init;
    logic    scan_rd;
    logic    pick;
    logic    emit;
    cnt_op_e cnt_op;
    cond_e   cond;
    step_e   target;
  } ctrl_t;

  typedef struct packed {
    logic clr_last;
    logic n_last;
    logic found;
    logic run_go;
  } stat_t;

endpackage

`default_nettype wire

### sv/pmw_seq.sv
`default_nettype none

module pmw_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pmw_pkg::stat_t stat_i,
  output pmw_pkg::ctrl_t ctrl_o
);
  import pmw_pkg::*;

  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c.busy     = 1'b1;
    c.clr_wr   = 1'b0;
    c.key_init = 1'b0;
    c.scan_rd  = 1'b0;
    c.pick     = 1'b0;
    c.emit     = 1'b0;
    c.cnt_op   = CNT_HOLD;
    c.cond     = C_NEXT;
    c.target   = ST_CLEAR;
    case (s)
      ST_CLEAR: begin
        c.clr_wr = 1'b1;
        c.cnt_op = CNT_INC;
        c.cond   = C_CLR_MORE;
        c.target = ST_CLEAR;
      end
      ST_IDLE: begin
        c.busy   = 1'b0;
        c.cond   = C_WAIT_RUN;
        c.target = ST_IDLE;
      end
      ST_INIT: begin
        c.key_init = 1'b1;
        c.cnt_op   = CNT_WRAP_N;
        c.cond     = C_N_MORE;
        c.target   = ST_INIT;
      end
      ST_SCAN: begin
        c.scan_rd = 1'b1;
        c.cnt_op  = CNT_WRAP_N;
        c.cond    = C_N_MORE;
        c.target  = ST_SCAN;
      end
      ST_DECIDE: begin
        c.cond   = C_NOT_FOUND;
        c.target = ST_EMIT;
      end
      ST_PICK: begin
        c.pick   = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = ST_SCAN;
      end
      ST_EMIT: begin
        c.emit   = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = ST_CLEAR;
      end
      default: ;
    endcase
    return c;
  endfunction

  step_e pc_q, pc_d;
  logic  jump;

  always_comb begin
    case (ctrl_o.cond)
      C_ALWAYS:    jump = 1'b1;
      C_CLR_MORE:  jump = ~stat_i.clr_last;
      C_WAIT_RUN:  jump = ~stat_i.run_go;
      C_N_MORE:    jump = ~stat_i.n_last;
      C_NOT_FOUND: jump = ~stat_i.found;
      default:     jump = 1'b0;
    endcase
    pc_d = jump ? ctrl_o.target : step_e'(3'(pc_q + 3'd1));
  end

  always_comb begin
    ctrl_o = ucode(pc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

### sv/pmw_dp.sv
`default_nettype none

module pmw_dp #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16,
  localparam int CW         = $clog2(MAX_NODES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pmw_pkg::ctrl_t                  ctrl_i,
  output pmw_pkg::stat_t                  stat_o,
  input  logic                            start_i,
  input  logic                            req_type_i,
  input  logic [pmw_pkg::NodeBits-1:0]    node_a_i,
  input  logic [pmw_pkg::NodeBits-1:0]    node_b_i,
  input  logic [pmw_pkg::InWBits-1:0]     edge_weight_i,
  input  logic [CW-1:0]                   n_i,
  output logic [pmw_pkg::TotalBits-1:0]   sum_o,
  output logic                            conn_o
);
  import pmw_pkg::*;

  localparam int NB = $clog2(MAX_NODES);
  localparam int AW = 2 * NB;
  localparam int WB = WEIGHT_BITS;
  localparam int KW = WB + 1;
  localparam int SW = ((WB > int'(TotalBits)) ? WB : int'(TotalBits)) + 1;
  localparam logic [KW-1:0] KeyInf = {1'b1, {WB{1'b0}}};

  logic [WB-1:0] adj_mem [2**AW];
  logic [KW:0]   key_mem [2**NB];

  logic [AW-1:0]    cnt_q, cnt_d;
  logic             rd_vld_q;
  logic [NB-1:0]    v_q;
  logic [WB-1:0]    adj_rd_q;
  logic [KW:0]      key_rd_q;
  logic [NB-1:0]    u_q, u_d, arg_q, arg_d;
  logic [KW-1:0]    min_q, min_d;
  logic [TotalBits-1:0] sum_q, sum_d;
  logic [CW-1:0]    picks_q, picks_d;

  logic                ld, a_ok, b_ok;
  logic [NodeBits-1:0] am1, bm1;
  logic [NB-1:0]       a_ix, b_ix, ld_lo, ld_hi, sc_lo, sc_hi, v_ix, nm1;
  logic [WB-1:0]       w_ld;
  logic                n_last;

  logic          in_t, is_u, relax, cand, kwr;
  logic [KW-1:0] key_old, key_new;
  logic [KW:0]   kwd;
  logic [SW-1:0] sum_ext;

  assign ld   = start_i & ~ctrl_i.busy & ~req_type_i;
  assign a_ok = (node_a_i != '0) && (int'(node_a_i) <= MAX_NODES);
  assign b_ok = (node_b_i != '0) && (int'(node_b_i) <= MAX_NODES);
  assign am1  = node_a_i - NodeBits'(1);
  assign bm1  = node_b_i - NodeBits'(1);
  assign a_ix = NB'(am1);
  assign b_ix = NB'(bm1);
  assign ld_lo = (a_ix < b_ix) ? a_ix : b_ix;
  assign ld_hi = (a_ix < b_ix) ? b_ix : a_ix;
  assign w_ld  = WB'(edge_weight_i);

  // upper triangle only: edge (x,y) lives at {min, max}
  assign v_ix  = cnt_q[NB-1:0];
  assign sc_lo = (u_q < v_ix) ? u_q : v_ix;
  assign sc_hi = (u_q < v_ix) ? v_ix : u_q;
  assign nm1   = NB'(n_i - CW'(1));
  assign n_last = (v_ix == nm1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_wr) begin
      adj_mem[cnt_q] <= '0;
    end else if (ld && a_ok && b_ok) begin
      adj_mem[{ld_lo, ld_hi}] <= w_ld;
    end
    if (ctrl_i.scan_rd) begin
      adj_rd_q <= adj_mem[{sc_lo, sc_hi}];
    end
  end

  assign in_t    = key_rd_q[KW];
  assign key_old = key_rd_q[KW-1:0];
  assign is_u    = (v_q == u_q);
  assign relax   = ~in_t & ~is_u & (adj_rd_q != '0) & ({1'b0, adj_rd_q} < key_old);
  assign key_new = relax ? {1'b0, adj_rd_q} : key_old;
  assign cand    = ~in_t & ~is_u & (key_new < min_q);
  assign kwr     = rd_vld_q & (is_u | relax);
  assign kwd     = {in_t | is_u, key_new};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.key_init) begin
      key_mem[v_ix] <= {1'b0, (v_ix == '0) ? {KW{1'b0}} : KeyInf};
    end else if (kwr) begin
      key_mem[v_q] <= kwd;
    end
    if (ctrl_i.scan_rd) begin
      key_rd_q <= key_mem[v_ix];
    end
  end

  always_comb begin
    case (ctrl_i.cnt_op)
      CNT_INC:    cnt_d = cnt_q + AW'(1);
      CNT_WRAP_N: cnt_d = n_last ? '0 : cnt_q + AW'(1);
      default:    cnt_d = cnt_q;
    endcase
  end

  assign sum_ext = SW'(sum_q) + SW'(min_q);

  always_comb begin
    u_d     = u_q;
    min_d   = min_q;
    arg_d   = arg_q;
    sum_d   = sum_q;
    picks_d = picks_q;
    if (ctrl_i.key_init) begin
      u_d     = '0;
      min_d   = KeyInf;
      sum_d   = '0;
      picks_d = CW'(1);
    end else if (ctrl_i.pick) begin
      u_d     = arg_q;
      min_d   = KeyInf;
      sum_d   = (|sum_ext[SW-1:TotalBits]) ? '1 : sum_ext[TotalBits-1:0];
      picks_d = picks_q + CW'(1);
    end else if (rd_vld_q && cand) begin
      min_d = key_new;
      arg_d = v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rd_vld_q <= ctrl_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_ix;
    u_q     <= u_d;
    min_q   <= min_d;
    arg_q   <= arg_d;
    sum_q   <= sum_d;
    picks_q <= picks_d;
  end

  assign stat_o.clr_last = &cnt_q;
  assign stat_o.n_last   = n_last;
  assign stat_o.found    = (min_q != KeyInf);
  assign stat_o.run_go   = start_i & ~ctrl_i.busy & req_type_i;

  assign sum_o  = sum_q;
  assign conn_o = (picks_q == n_i);

endmodule

`default_nettype wire

### sv/prim_mst_weight_top.sv
`default_nettype none
// Minimum spanning tree weight, dense Prim over an adjacency matrix.
// Command channel: an item is taken when start is high and busy is low.
//   req_type_i = 0 loads edge (node_a_i, node_b_i) with edge_weight_i;
//   busy stays low, so loads may follow every cycle. Weight 0 removes.
//   req_type_i = 1 runs Prim from node 1 over node_count nodes; busy is high.
// Result: total_weight_o and connected_o are valid for the single cycle in
//   which done_o is high; the receiver cannot stall, so nothing waits there.
// Run: the key RAM is first initialised over the active nodes; each reached
//   node then costs one sweep of the key and matrix RAMs (one read port
//   each) plus three sequencer steps.
// After each result, and after reset, the matrix is cleared one entry a
//   cycle, all 2**(2*clog2(MAX_NODES)) entries (4096 at 64 nodes), busy high.
// Configuration: cfg_we_i writes node_count (reset 1) at any time; writes
//   are meant only while idle. 0 acts as 1, values above MAX_NODES saturate.
// Reset is asynchronous, active low; no result is pending after it.

module prim_mst_weight_top #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pmw_pkg::NodeBits-1:0]    cfg_wdata_i,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type_i,
  input  logic [pmw_pkg::NodeBits-1:0]    node_a_i,
  input  logic [pmw_pkg::NodeBits-1:0]    node_b_i,
  input  logic [pmw_pkg::InWBits-1:0]     edge_weight_i,
  output logic                            done_o,
  output logic [pmw_pkg::TotalBits-1:0]   total_weight_o,
  output logic                            connected_o
);
  import pmw_pkg::*;

  localparam int CW = $clog2(MAX_NODES + 1);

  ctrl_t ctrl;
  stat_t stat;

  logic [NodeBits-1:0]  node_count_q;
  logic [CW-1:0]        n_act;
  logic [TotalBits-1:0] sum, total_q;
  logic                 conn, conn_q, done_q;

  always_comb begin
    if (node_count_q == '0) begin
      n_act = CW'(1);
    end else if (int'(node_count_q) > MAX_NODES) begin
      n_act = CW'(MAX_NODES);
    end else begin
      n_act = CW'(node_count_q);
    end
  end

  pmw_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  pmw_dp #(
    .MAX_NODES   (MAX_NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .start_i       (start),
    .req_type_i    (req_type_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .edge_weight_i (edge_weight_i),
    .n_i           (n_act),
    .sum_o         (sum),
    .conn_o        (conn)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeBits'(1);
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      done_q <= ctrl.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      total_q <= sum;
      conn_q  <= conn;
    end
  end

  assign busy           = ctrl.busy;
  assign done_o         = done_q;
  assign total_weight_o = total_q;
  assign connected_o    = conn_q;

endmodule

`default_nettype wire

### sv/pmw_chk.sv
`default_nettype none

module pmw_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic req_type_i,
  input logic done_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result shown while idle");

  a_idle_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !done_o)
    else $error("result right after an idle cycle");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i) |=> busy)
    else $error("run item did not raise busy");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !req_type_i) |=> !busy)
    else $error("load item stalled the channel");

endmodule

bind prim_mst_weight_top pmw_chk u_pmw_chk (.*);

`default_nettype wire
